// ===== src/tced_pkg.sv =====
// ----------------------------------------------------------------------------
// tced_pkg
// Shared sizes, constants and types of the two-plane e-paper downscaler.
// ----------------------------------------------------------------------------
package tced_pkg;

    // Output raster size in cells (each cell is 3x3 input pixels)
    localparam int OUT_WIDTH  = 128;
    localparam int OUT_HEIGHT = 128;

    // Field widths fixed by the stream format
    localparam int CHAN_W  = 8;
    localparam int COORD_W = 10;
    localparam int SLOT_W  = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;

    // Position inside a cell: 0 and 1 are sampled, 2 is skipped
    localparam logic [1:0] CELL_FIRST = 2'd0;
    localparam logic [1:0] CELL_SECOND = 2'd1;
    localparam logic [1:0] CELL_LAST  = 2'd2;

    localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd120;

    // Result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One finished cell as it travels from front to back
    typedef struct packed {
        logic               dark_plane_bit;
        logic               red_plane_bit;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
    } tced_result_t;

    // Push side of the result queue
    typedef struct packed {
        logic         valid;
        tced_result_t result;
    } tced_push_t;

endpackage

// ===== src/two_color_epaper_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// two_color_epaper_downscaler_top
// Reduces an RGB raster 3*OUT_WIDTH x 3*OUT_HEIGHT to two-plane e-paper cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one RGB pixel per transfer in raster order; tuser
//   high marks the first pixel of a frame and restarts the position. The
//   position also wraps on its own after 3*OUT_HEIGHT rows.
//   Master stream carries one result per 3x3 cell, issued when the cell's
//   bottom-right sampled pixel arrives; tlast marks the last cell of a frame.
//   The cfg channel writes the color threshold (always ready); write it only
//   while no pixel is in flight.
// Throughput: one pixel per clock while the queue has room. The front classifies
//   and updates the line store in the accept cycle and reads it one pixel ahead.
// Result path: the result enters the queue at the accepting edge and loads
//   into the output register, which drives m_tvalid, once that register is
//   empty or its transfer completes.
// Reset: position, vote registers, queue and output valid clear; threshold
//   returns to 120. The line store needs no clearing.
// Stall: a stalled receiver holds the output register; the four-entry queue
//   absorbs results and s_tready drops only when it is full.
// ----------------------------------------------------------------------------
module two_color_epaper_downscaler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // dark_plane_bit[0], red_plane_bit[1],
                                   // out_column[11:2], out_row[21:12], zero[23:22]
    output logic        m_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // color_threshold
);
    import tced_pkg::*;

    logic         accept;
    logic         q_full, q_not_empty, q_pop;
    tced_push_t   push;
    tced_result_t q_head;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    tced_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .red         (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .blue        (s_tdata[23:16]),
        .frame_start (s_tuser),
        .cfg_write   (cfg_valid),
        .cfg_value   (cfg_data),
        .push        (push)
    );

    tced_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tced_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== src/tced_front.sv =====
// ----------------------------------------------------------------------------
// tced_front
// Tracks the raster position, classifies sampled pixels against the
// threshold, keeps the line store of first-row counts and emits one result
// per cell on its bottom-right sampled pixel.
// ----------------------------------------------------------------------------
module tced_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [tced_pkg::CHAN_W-1:0] red,
    input  logic [tced_pkg::CHAN_W-1:0] green,
    input  logic [tced_pkg::CHAN_W-1:0] blue,
    input  logic                        frame_start,
    input  logic                        cfg_write,
    input  logic [tced_pkg::CHAN_W-1:0] cfg_value,
    output tced_pkg::tced_push_t        push
);
    import tced_pkg::*;

    logic [CHAN_W-1:0]  threshold_reg;
    logic [1:0]         cx_reg, cx_next;
    logic [1:0]         cy_reg, cy_next;
    logic [COORD_W-1:0] ocol_reg, ocol_next;
    logic [COORD_W-1:0] orow_reg, orow_next;
    logic               pair_dark_reg, pair_red_reg;
    logic [3:0]         line_store [OUT_WIDTH];
    logic [3:0]         prev_reg;

    logic [1:0]         cx_cur, cy_cur;
    logic [COORD_W-1:0] ocol_cur, orow_cur;
    logic [SLOT_W-1:0]  slot;
    logic               low_gb, is_red, is_dark;
    logic               sampled;
    logic [2:0]         dark_sum, red_sum;
    logic [1:0]         first_dark, first_red;

    // Frame start restarts the position before this pixel is used
    always_comb
    begin
        cx_cur   = frame_start ? CELL_FIRST : cx_reg;
        cy_cur   = frame_start ? CELL_FIRST : cy_reg;
        ocol_cur = frame_start ? '0 : ocol_reg;
        orow_cur = frame_start ? '0 : orow_reg;
        slot     = ocol_cur[SLOT_W-1:0];
        sampled  = (cx_cur != CELL_LAST) && (cy_cur != CELL_LAST);
    end

    // Classify: red wins over dark
    always_comb
    begin
        low_gb  = (green <= threshold_reg) && (blue <= threshold_reg);
        is_red  = (red >= threshold_reg) && low_gb;
        is_dark = !is_red && (red <= threshold_reg) && low_gb;
    end

    // Advance the position, wrapping column then row
    always_comb
    begin
        cx_next   = cx_cur;
        cy_next   = cy_cur;
        ocol_next = ocol_cur;
        orow_next = orow_cur;
        if (cx_cur == CELL_LAST)
        begin
            cx_next = CELL_FIRST;
            if (ocol_cur == COORD_W'(OUT_WIDTH - 1))
            begin
                ocol_next = '0;
                if (cy_cur == CELL_LAST)
                begin
                    cy_next = CELL_FIRST;
                    if (orow_cur == COORD_W'(OUT_HEIGHT - 1))
                        orow_next = '0;
                    else
                        orow_next = orow_cur + 1'b1;
                end
                else
                begin
                    cy_next = cy_cur + 1'b1;
                end
            end
            else
            begin
                ocol_next = ocol_cur + 1'b1;
            end
        end
        else
        begin
            cx_next = cx_cur + 1'b1;
        end
    end

    // Hold threshold, position and the first sampled pixel's votes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            cx_reg        <= CELL_FIRST;
            cy_reg        <= CELL_FIRST;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            pair_dark_reg <= 1'b0;
            pair_red_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                threshold_reg <= cfg_value;
            if (accept)
            begin
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                ocol_reg <= ocol_next;
                orow_reg <= orow_next;
                if (sampled && (cx_cur == CELL_FIRST))
                begin
                    pair_dark_reg <= is_dark;
                    pair_red_reg  <= is_red;
                end
            end
        end
    end

    // Counts of the first sampled row of a cell
    always_comb
    begin
        first_dark = {1'b0, pair_dark_reg} + {1'b0, is_dark};
        first_red  = {1'b0, pair_red_reg} + {1'b0, is_red};
    end

    // Line store: write in cell row 0, read ahead on cell row 1 column 0
    always_ff @(posedge clk)
    begin
        if (accept && (cy_cur == CELL_FIRST) && (cx_cur == CELL_SECOND))
            line_store[slot] <= {first_red, first_dark};
        if (accept && (cy_cur == CELL_SECOND) && (cx_cur == CELL_FIRST))
            prev_reg <= line_store[slot];
    end

    // Vote over the four sampled pixels
    always_comb
    begin
        dark_sum = {1'b0, prev_reg[1:0]} + {2'b0, pair_dark_reg} + {2'b0, is_dark};
        red_sum  = {1'b0, prev_reg[3:2]} + {2'b0, pair_red_reg} + {2'b0, is_red};
        push.valid = accept && (cy_cur == CELL_SECOND) && (cx_cur == CELL_SECOND);
        push.result.dark_plane_bit = (dark_sum >= 3'd2) ? 1'b0 : 1'b1;
        push.result.red_plane_bit  = (red_sum >= 3'd2) ? 1'b0 : 1'b1;
        push.result.out_column     = ocol_cur;
        push.result.out_row        = orow_cur;
    end

endmodule

// ===== src/tced_queue.sv =====
// ----------------------------------------------------------------------------
// tced_queue
// Short result queue that decouples the pixel side from the output side.
// ----------------------------------------------------------------------------
module tced_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tced_pkg::tced_push_t   push,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output tced_pkg::tced_result_t head
);
    import tced_pkg::*;

    tced_result_t       entries [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push.valid)
            entries[wr_ptr_reg] <= push.result;
    end

endmodule

// ===== src/tced_back.sv =====
// ----------------------------------------------------------------------------
// tced_back
// Output register: takes results from the queue, marks the last cell of a
// frame and holds the transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module tced_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_not_empty,
    input  tced_pkg::tced_result_t q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tlast
);
    import tced_pkg::*;

    logic         valid_reg;
    tced_result_t data_reg;
    logic         last_reg;
    logic         load;

    // Load when the register is empty or its transfer completes
    assign load  = q_not_empty && (!valid_reg || m_tready);
    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= q_head;
            last_reg <= (q_head.out_column == COORD_W'(OUT_WIDTH - 1)) &&
                        (q_head.out_row == COORD_W'(OUT_HEIGHT - 1));
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, data_reg.out_row, data_reg.out_column,
                       data_reg.red_plane_bit, data_reg.dark_plane_bit};

endmodule

// ===== src/tced_checker.sv =====
// ----------------------------------------------------------------------------
// tced_checker
// Port-level checks of the downscaler's output stream.
// ----------------------------------------------------------------------------
module tced_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    import tced_pkg::*;

    // Hold a stalled transfer
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // Frame end only on the last cell position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |->
            (m_tdata[11:2] == COORD_W'(OUT_WIDTH - 1)) &&
            (m_tdata[21:12] == COORD_W'(OUT_HEIGHT - 1)))
        else $error("tlast on a cell that is not the last of the frame");

    // Coordinates stay inside the output raster
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:2] <= COORD_W'(OUT_WIDTH - 1)) &&
                     (m_tdata[21:12] <= COORD_W'(OUT_HEIGHT - 1)))
        else $error("output cell coordinate out of range");

    // No result in the cycle after reset is seen
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind two_color_epaper_downscaler_top tced_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_two_color_epaper_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// tb_two_color_epaper_downscaler_top
// Self-checking bench for the two-plane e-paper downscaler.
// ----------------------------------------------------------------------------
// Drives RGB pixel runs on the slave stream and tracks raster position, line
// store and vote counts in a scoreboard. Each pixel transfer updates the
// prediction. Each master transfer is checked against the oldest predicted
// cell. The run covers the reset threshold, both threshold extremes and a
// random one, field extremes, mid-frame restarts and truncated runs. Sender
// gaps and receiver stalls vary by stage. One long receiver stall fills the
// result queue so that the input backs up.
// ----------------------------------------------------------------------------
module tb_two_color_epaper_downscaler_top;

    import tced_pkg::*;

    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 10;
    localparam int SETTLE_CYCLES     = 6;
    localparam int LONG_STALL_CYCLES = 1200;
    localparam int TIMEOUT_CYCLES    = 2_000_000;
    localparam int LINE_PIXELS       = 3 * OUT_WIDTH;

    // Vote layout: dark count in bits 1..0, red count in bits 3..2
    localparam logic [3:0] NO_VOTE   = 4'b0000;
    localparam logic [3:0] DARK_VOTE = 4'b0001;
    localparam logic [3:0] RED_VOTE  = 4'b0100;

    // One expected output cell
    typedef struct packed {
        tced_result_t result;
        logic         frame_last;
    } cell_t;

    // ------------------------------------------------------------------------
    // Scoreboard: raster position, line store and pending cells
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        logic [7:0]  threshold;
        int unsigned col;
        int unsigned row;
        logic [3:0]  line_votes [OUT_WIDTH];
        logic [3:0]  pair_votes;
        cell_t       pending [$];
        int          errors;

        function new();
            threshold  = THRESHOLD_RESET;
            col        = 0;
            row        = 0;
            pair_votes = NO_VOTE;
            errors     = 0;
            foreach (line_votes[i])
                line_votes[i] = NO_VOTE;
        endfunction

        function void set_threshold(logic [7:0] t);
            threshold = t;
        endfunction

        // Red wins over dark when both hold
        function logic [3:0] classify_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic low_gb;
            low_gb = (g <= threshold) && (b <= threshold);
            if (r >= threshold && low_gb)
                return RED_VOTE;
            if (r <= threshold && low_gb)
                return DARK_VOTE;
            return NO_VOTE;
        endfunction

        // Advance the raster by one accepted pixel
        function void note_pixel(logic [23:0] data, logic frame_start);
            logic [1:0]  cx;
            logic [1:0]  cy;
            int unsigned ocol;
            int unsigned orow;
            int unsigned slot;
            int unsigned dark_sum;
            int unsigned red_sum;
            logic [3:0]  v;
            logic [3:0]  prev;
            cell_t       exp_cell;
            if (frame_start) begin
                col = 0;
                row = 0;
            end
            cx   = 2'(col % 3);
            cy   = 2'(row % 3);
            ocol = col / 3;
            orow = row / 3;
            slot = ocol % OUT_WIDTH;
            if (cx != CELL_LAST && cy != CELL_LAST) begin
                v = classify_pixel(data[7:0], data[15:8], data[23:16]);
                if (cx == CELL_FIRST)
                    pair_votes = v;
                else if (cy == CELL_FIRST)
                    line_votes[slot] = pair_votes + v;
                else begin
                    prev     = line_votes[slot];
                    dark_sum = prev[1:0] + pair_votes[1:0] + v[1:0];
                    red_sum  = prev[3:2] + pair_votes[3:2] + v[3:2];
                    exp_cell.result.dark_plane_bit = (dark_sum >= 2) ? 1'b0 : 1'b1;
                    exp_cell.result.red_plane_bit  = (red_sum >= 2) ? 1'b0 : 1'b1;
                    exp_cell.result.out_column     = COORD_W'(ocol);
                    exp_cell.result.out_row        = COORD_W'(orow);
                    exp_cell.frame_last = (ocol == OUT_WIDTH - 1) &&
                                          (orow == OUT_HEIGHT - 1);
                    pending.push_back(exp_cell);
                end
            end
            // Wrap column, then row
            col++;
            if (col >= LINE_PIXELS) begin
                col = 0;
                row++;
                if (row >= 3 * OUT_HEIGHT)
                    row = 0;
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // Check one output transfer against the oldest expected cell
        function void check_cell(logic [23:0] data, logic last);
            cell_t want;
            if (pending.size() == 0) begin
                $error("output transfer with no cell expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("dark_plane_bit", want.result.dark_plane_bit, data[0]);
            compare_field("red_plane_bit", want.result.red_plane_bit, data[1]);
            compare_field("out_column", want.result.out_column, data[11:2]);
            compare_field("out_row", want.result.out_row, data[21:12]);
            compare_field("tdata padding", 0, data[23:22]);
            compare_field("frame_last", want.frame_last, last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    bit          stall_req      = 1'b0;

    cell_scoreboard board;

    two_color_epaper_downscaler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Monitor both streams at the transfer edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                board.check_cell(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                board.note_pixel(s_tdata, s_tuser);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever begin
            @(posedge clk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pixel generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_at_most(logic [7:0] t);
        case ($urandom_range(3))
            0: return 8'd0;
            1: return t;
            default: return 8'($urandom_range(t));
        endcase
    endfunction

    function automatic logic [7:0] pick_at_least(logic [7:0] t);
        case ($urandom_range(3))
            0: return 8'd255;
            1: return t;
            default: return 8'($urandom_range(255, t));
        endcase
    endfunction

    function automatic logic [7:0] pick_near(logic [7:0] t);
        int v;
        v = int'(t) + int'($urandom_range(2)) - 1;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Mix red-like, dark-like, near-threshold and fully random pixels
    function automatic logic [23:0] make_pixel(logic [7:0] t);
        case ($urandom_range(3))
            0: return {pick_at_most(t), pick_at_most(t), pick_at_least(t)};
            1: return {pick_at_most(t), pick_at_most(t), pick_at_most(t)};
            2: return {pick_near(t), pick_near(t), pick_near(t)};
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one pixel and hold it until the transfer
    task automatic feed_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Raster run; noise sets the per-mille chance of a stray frame start
    task automatic feed_run(input int len, input logic first_fs, input int noise);
        logic [23:0] px;
        logic        fs;
        for (int i = 0; i < len; i++) begin
            px = make_pixel(board.threshold);
            fs = (i == 0) ? first_fs : ($urandom_range(999) < noise);
            feed_pixel(px[7:0], px[15:8], px[23:16], fs);
        end
    endtask

    // Mostly well-formed runs through two pixel rows, some short broken runs
    task automatic feed_mix(input int count);
        int left;
        int len;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 75) begin
                len = 2 * LINE_PIXELS + $urandom_range(LINE_PIXELS / 2);
                if (len > left)
                    len = left;
                feed_run(len, 1'b1, 1);
            end
            else begin
                len = $urandom_range(1, 200);
                if (len > left)
                    len = left;
                feed_run(len, 1'($urandom_range(1)), 20);
            end
            left -= len;
        end
    endtask

    // Drop valid, drain expected cells, then let the pipeline go quiet
    task automatic wait_settled();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_threshold(t);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stage 1: sender idles lightly, receiver stalls half the time
        send_gap_pct   = 24;
        recv_stall_pct = 50;

        // Field extremes and threshold edges at the reset threshold
        feed_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        feed_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        feed_pixel(THRESHOLD_RESET, THRESHOLD_RESET, THRESHOLD_RESET, 1'b0);
        feed_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        feed_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        feed_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        feed_pixel(THRESHOLD_RESET - 1, THRESHOLD_RESET + 1, THRESHOLD_RESET - 1, 1'b0);
        feed_pixel(THRESHOLD_RESET + 1, THRESHOLD_RESET - 1, THRESHOLD_RESET + 1, 1'b0);
        feed_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        feed_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        feed_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        // Restart mid-row
        feed_pixel(8'd1, 8'd2, 8'd3, 1'b1);
        feed_pixel(8'd128, 8'd64, 8'd32, 1'b0);
        feed_pixel(THRESHOLD_RESET, 8'd0, 8'd0, 1'b0);
        feed_run(LINE_PIXELS + 24, 1'b1, 0);
        wait_settled();

        // Stage 2: roles swapped; threshold extremes, broken runs
        send_gap_pct   = 50;
        recv_stall_pct = 24;
        write_threshold(8'd0);
        feed_mix(100);
        wait_settled();
        write_threshold(8'd255);
        feed_run(LINE_PIXELS + 24, 1'b1, 0);
        wait_settled();

        // Stage 3: no idling; long receiver hold-off backs up the input
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_threshold(8'($urandom_range(1, 254)));
        stall_req = 1'b1;
        feed_run(LINE_PIXELS + 48, 1'b1, 0);
        wait_settled();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
